@@ hw/rtl/fsc_pkg.sv @@
// ----------------------------------------------------------------------------
// Fisheye source coordinate package
// Shared defaults, register indexes and result action codes.
// ----------------------------------------------------------------------------
package fsc_pkg;

   localparam int MAX_DIM_DEFAULT   = 4096;
   localparam int FRAC_BITS_DEFAULT = 16;

   // Register reset values.
   localparam int IMAGE_WIDTH_RESET  = 1920;
   localparam int IMAGE_HEIGHT_RESET = 1080;
   localparam int ROI_X_BEGIN_RESET  = 0;
   localparam int ROI_X_END_RESET    = 1920;
   localparam int ROI_Y_BEGIN_RESET  = 0;
   localparam int ROI_Y_END_RESET    = 1080;

   localparam int CSR_INDEX_W = 3;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_IMAGE_WIDTH  = 3'd0,
      CSR_IMAGE_HEIGHT = 3'd1,
      CSR_ROI_X_BEGIN  = 3'd2,
      CSR_ROI_X_END    = 3'd3,
      CSR_ROI_Y_BEGIN  = 3'd4,
      CSR_ROI_Y_END    = 3'd5
   } csr_index_type;

   typedef enum logic [1:0] {
      ACT_COPY = 2'd0,
      ACT_ZERO = 2'd1,
      ACT_KEEP = 2'd2
   } action_type;

endpackage

@@ hw/rtl/fsc_div_cell.sv @@
// ----------------------------------------------------------------------------
// Fisheye divider cell
// One restoring division step: resolves one quotient bit and passes the
// partial remainder, divisor and quotient on to the next cell.
// ----------------------------------------------------------------------------
module fsc_div_cell #(
   parameter int DEN_W = 13,
   parameter int QUO_W = 18,
   parameter int BIT   = 0
) (
   input  logic                     clock,
   input  logic                     en,
   input  logic [DEN_W+QUO_W-1:0]   rem_i,
   input  logic [DEN_W-1:0]         den_i,
   input  logic [QUO_W-1:0]         quo_i,
   output logic [DEN_W+QUO_W-1:0]   rem_o,
   output logic [DEN_W-1:0]         den_o,
   output logic [QUO_W-1:0]         quo_o
);

   localparam int REM_W = DEN_W + QUO_W;

   logic [REM_W-1:0] trial;
   logic             ge;
   logic [REM_W-1:0] rem_in, rem_ff;
   logic [QUO_W-1:0] quo_in, quo_ff;
   logic [DEN_W-1:0] den_ff;

   always_comb begin
      trial  = REM_W'(den_i) << BIT;
      ge     = (rem_i >= trial);
      rem_in = ge ? (rem_i - trial) : rem_i;
      quo_in = quo_i | (QUO_W'(ge) << BIT);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff <= rem_in;
         quo_ff <= quo_in;
         den_ff <= den_i;
      end
   end

   assign rem_o = rem_ff;
   assign den_o = den_ff;
   assign quo_o = quo_ff;

endmodule

@@ hw/rtl/fsc_sqrt_cell.sv @@
// ----------------------------------------------------------------------------
// Fisheye square root cell
// One digit-by-digit square root step: decides one root bit and passes the
// remaining radicand and the partial root on to the next cell.
// ----------------------------------------------------------------------------
module fsc_sqrt_cell #(
   parameter int ROOT_W = 17,
   parameter int BIT    = 0
) (
   input  logic                  clock,
   input  logic                  en,
   input  logic [2*ROOT_W-1:0]   rem_i,
   input  logic [ROOT_W-1:0]     root_i,
   output logic [2*ROOT_W-1:0]   rem_o,
   output logic [ROOT_W-1:0]     root_o
);

   localparam int VAL_W = 2 * ROOT_W;

   logic [VAL_W-1:0]  trial;
   logic              ge;
   logic [VAL_W-1:0]  rem_in, rem_ff;
   logic [ROOT_W-1:0] root_in, root_ff;

   // (root + 2^BIT)^2 - root^2 = root * 2^(BIT+1) + 2^(2*BIT)
   always_comb begin
      trial   = (VAL_W'(root_i) << (BIT + 1)) + (VAL_W'(1) << (2 * BIT));
      ge      = (rem_i >= trial);
      rem_in  = ge ? (rem_i - trial) : rem_i;
      root_in = root_i | (ROOT_W'(ge) << BIT);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff  <= rem_in;
         root_ff <= root_in;
      end
   end

   assign rem_o  = rem_ff;
   assign root_o = root_ff;

endmodule

@@ hw/rtl/fisheye_source_coordinate.sv @@
// ----------------------------------------------------------------------------
// Fisheye source coordinate generator
// Maps each destination pixel to the source pixel of a radial fisheye remap
// and chooses whether to copy it, clear the destination or leave it alone.
// ----------------------------------------------------------------------------
// The block takes one request per clock cycle and returns one response per
// request, in order. Most of its depth lies in three rows of bit cells: a
// restoring divider that normalizes the coordinates (FRAC_BITS+2 cells), two
// square root rows running side by side (FRAC_BITS+1 cells) and a second
// divider that rescales the remapped radius along the pixel direction
// (FRAC_BITS+1 cells). All stages move together; when a response is held back
// by rsp_ready the whole pipeline holds, and it keeps taking requests as long
// as the final register is empty or being taken. Registers are sampled live
// and should only be written while no request is in flight.
// ----------------------------------------------------------------------------
module fisheye_source_coordinate #(
   parameter int MAX_DIM   = fsc_pkg::MAX_DIM_DEFAULT,
   parameter int FRAC_BITS = fsc_pkg::FRAC_BITS_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [$clog2(MAX_DIM)-1:0]        req_dst_x,
   input  logic [$clog2(MAX_DIM)-1:0]        req_dst_y,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [$clog2(MAX_DIM):0]          rsp_src_x,
   output logic [$clog2(MAX_DIM):0]          rsp_src_y,
   output logic [1:0]                        rsp_action,
   input  logic                              csr_wr_en,
   input  logic [fsc_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [$clog2(MAX_DIM):0]          csr_wdata
);

   import fsc_pkg::*;

   localparam int F     = FRAC_BITS;
   localparam int DW    = $clog2(MAX_DIM);   // coordinate width
   localparam int RW    = DW + 1;            // register width
   localparam int QW    = F + 2;             // normalized quotient width
   localparam int AW    = F + 1;             // magnitude width
   localparam int SQW   = 2 * AW + 1;        // sum of squares width
   localparam int RTW   = F + 1;             // root width
   localparam int VW    = 2 * RTW;           // radicand width
   localparam int PW    = 2 * AW;            // radius product width
   localparam int N1    = QW;                // normalizing divider cells
   localparam int N2    = RTW;               // square root cells
   localparam int N3    = AW;                // direction divider cells
   localparam int DEPTH = 9 + N1 + N2 + N3;
   localparam int PXW   = QW + RW;           // pixel scale product width

   localparam logic [QW-1:0]  ONE       = QW'(1) << F;
   localparam logic [QW-1:0]  THREE_ONE = ONE + (ONE << 1);
   localparam logic [SQW-1:0] ONE_SQ    = SQW'(1) << (2 * F);

   typedef struct packed {
      logic sat_x;
      logic sat_y;
      logic bad;
   } nrm_side_type;

   typedef struct packed {
      logic [AW-1:0] ax;
      logic [AW-1:0] ay;
      logic          neg_x;
      logic          neg_y;
      logic          outside;
   } rad_side_type;

   typedef struct packed {
      logic neg_x;
      logic neg_y;
      logic outside;
   } dir_side_type;

   // ------------------------------------------------------------------------
   // Configuration registers
   // ------------------------------------------------------------------------
   logic [RW-1:0] width_ff, height_ff;
   logic [RW-1:0] roi_xb_ff, roi_xe_ff, roi_yb_ff, roi_ye_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= RW'(IMAGE_WIDTH_RESET);
         height_ff <= RW'(IMAGE_HEIGHT_RESET);
         roi_xb_ff <= RW'(ROI_X_BEGIN_RESET);
         roi_xe_ff <= RW'(ROI_X_END_RESET);
         roi_yb_ff <= RW'(ROI_Y_BEGIN_RESET);
         roi_ye_ff <= RW'(ROI_Y_END_RESET);
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_IMAGE_WIDTH:  width_ff  <= csr_wdata;
            CSR_IMAGE_HEIGHT: height_ff <= csr_wdata;
            CSR_ROI_X_BEGIN:  roi_xb_ff <= csr_wdata;
            CSR_ROI_X_END:    roi_xe_ff <= csr_wdata;
            CSR_ROI_Y_BEGIN:  roi_yb_ff <= csr_wdata;
            CSR_ROI_Y_END:    roi_ye_ff <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // ------------------------------------------------------------------------
   // Flow control: every stage advances together whenever the output
   // register is empty or its response is being taken.
   // ------------------------------------------------------------------------
   logic             adv;
   logic [DEPTH-1:0] vld_ff;

   assign adv       = !vld_ff[DEPTH-1] || rsp_ready;
   assign req_ready = adv;
   assign rsp_valid = vld_ff[DEPTH-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[DEPTH-2:0], req_valid};
      end
   end

   // ------------------------------------------------------------------------
   // Stage A: input register
   // ------------------------------------------------------------------------
   logic [DW-1:0] a_x_ff, a_y_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         a_x_ff <= req_dst_x;
         a_y_ff <= req_dst_y;
      end
   end

   // ------------------------------------------------------------------------
   // Normalizing divider: q = (dst * 2^(F+1)) / size. A position at or past
   // twice the size saturates, so the quotient never needs more than F+2 bits.
   // ------------------------------------------------------------------------
   logic [RW+QW-1:0] n1x_rem [N1+1];
   logic [RW-1:0]    n1x_den [N1+1];
   logic [QW-1:0]    n1x_quo [N1+1];
   logic [RW+QW-1:0] n1y_rem [N1+1];
   logic [RW-1:0]    n1y_den [N1+1];
   logic [QW-1:0]    n1y_quo [N1+1];
   nrm_side_type     n1_side_in;
   nrm_side_type     n1_side_ff [N1];

   always_comb begin
      n1x_rem[0] = (RW+QW)'(a_x_ff) << (F + 1);
      n1x_den[0] = width_ff;
      n1x_quo[0] = '0;
      n1y_rem[0] = (RW+QW)'(a_y_ff) << (F + 1);
      n1y_den[0] = height_ff;
      n1y_quo[0] = '0;
      n1_side_in.sat_x = ((DW+2)'(a_x_ff) >= ((DW+2)'(width_ff) << 1));
      n1_side_in.sat_y = ((DW+2)'(a_y_ff) >= ((DW+2)'(height_ff) << 1));
      n1_side_in.bad   = (width_ff == '0) || (height_ff == '0);
   end

   for (genvar k = 0; k < N1; k++) begin : g_norm
      fsc_div_cell #(.DEN_W(RW), .QUO_W(QW), .BIT(N1 - 1 - k)) u_cell_x (
         .clock (clock),
         .en    (adv),
         .rem_i (n1x_rem[k]),
         .den_i (n1x_den[k]),
         .quo_i (n1x_quo[k]),
         .rem_o (n1x_rem[k+1]),
         .den_o (n1x_den[k+1]),
         .quo_o (n1x_quo[k+1])
      );
      fsc_div_cell #(.DEN_W(RW), .QUO_W(QW), .BIT(N1 - 1 - k)) u_cell_y (
         .clock (clock),
         .en    (adv),
         .rem_i (n1y_rem[k]),
         .den_i (n1y_den[k]),
         .quo_i (n1y_quo[k]),
         .rem_o (n1y_rem[k+1]),
         .den_o (n1y_den[k+1]),
         .quo_o (n1y_quo[k+1])
      );
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         n1_side_ff[0] <= n1_side_in;
         for (int k = 1; k < N1; k++) begin
            n1_side_ff[k] <= n1_side_ff[k-1];
         end
      end
   end

   // ------------------------------------------------------------------------
   // Stage B: signed normalized coordinate as magnitude and sign. The value
   // is q - 1.0, saturated at just under 2.0.
   // ------------------------------------------------------------------------
   logic [AW-1:0] b_ax_in, b_ay_in, b_ax_ff, b_ay_ff;
   logic          b_nx_in, b_ny_in, b_nx_ff, b_ny_ff, b_bad_ff;
   logic [QW-1:0] qx, qy;

   always_comb begin
      qx = n1x_quo[N1];
      qy = n1y_quo[N1];
      if (n1_side_ff[N1-1].sat_x || (qx >= THREE_ONE)) begin
         b_ax_in = AW'((ONE << 1) - QW'(1));
         b_nx_in = 1'b0;
      end else if (qx < ONE) begin
         b_ax_in = AW'(ONE - qx);
         b_nx_in = 1'b1;
      end else begin
         b_ax_in = AW'(qx - ONE);
         b_nx_in = 1'b0;
      end
      if (n1_side_ff[N1-1].sat_y || (qy >= THREE_ONE)) begin
         b_ay_in = AW'((ONE << 1) - QW'(1));
         b_ny_in = 1'b0;
      end else if (qy < ONE) begin
         b_ay_in = AW'(ONE - qy);
         b_ny_in = 1'b1;
      end else begin
         b_ay_in = AW'(qy - ONE);
         b_ny_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         b_ax_ff  <= b_ax_in;
         b_ay_ff  <= b_ay_in;
         b_nx_ff  <= b_nx_in;
         b_ny_ff  <= b_ny_in;
         b_bad_ff <= n1_side_ff[N1-1].bad;
      end
   end

   // ------------------------------------------------------------------------
   // Stage C: squares of the two magnitudes
   // ------------------------------------------------------------------------
   logic [PW-1:0] c_xsq_ff, c_ysq_ff;
   rad_side_type  c_side_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         c_xsq_ff          <= PW'(b_ax_ff) * PW'(b_ax_ff);
         c_ysq_ff          <= PW'(b_ay_ff) * PW'(b_ay_ff);
         c_side_ff.ax      <= b_ax_ff;
         c_side_ff.ay      <= b_ay_ff;
         c_side_ff.neg_x   <= b_nx_ff;
         c_side_ff.neg_y   <= b_ny_ff;
         c_side_ff.outside <= b_bad_ff;
      end
   end

   // ------------------------------------------------------------------------
   // Stage D: squared radius, the unit circle test, and 1 - d^2
   // ------------------------------------------------------------------------
   logic [SQW-1:0] d_sum;
   logic [VW-1:0]  d_d2_ff, d_e2_ff;
   rad_side_type   d_side_in, d_side_ff;

   always_comb begin
      d_sum             = SQW'(c_xsq_ff) + SQW'(c_ysq_ff);
      d_side_in         = c_side_ff;
      d_side_in.outside = c_side_ff.outside || (d_sum > ONE_SQ);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         d_d2_ff   <= d_sum[VW-1:0];
         d_e2_ff   <= ONE_SQ[VW-1:0] - d_sum[VW-1:0];
         d_side_ff <= d_side_in;
      end
   end

   // ------------------------------------------------------------------------
   // Two square root rows: d = sqrt(d^2) and s = sqrt(1 - d^2)
   // ------------------------------------------------------------------------
   logic [VW-1:0]  sqd_rem [N2+1];
   logic [RTW-1:0] sqd_root [N2+1];
   logic [VW-1:0]  sqs_rem [N2+1];
   logic [RTW-1:0] sqs_root [N2+1];
   rad_side_type   sq_side_ff [N2];

   assign sqd_rem[0]  = d_d2_ff;
   assign sqd_root[0] = '0;
   assign sqs_rem[0]  = d_e2_ff;
   assign sqs_root[0] = '0;

   for (genvar k = 0; k < N2; k++) begin : g_sqrt
      fsc_sqrt_cell #(.ROOT_W(RTW), .BIT(N2 - 1 - k)) u_cell_d (
         .clock  (clock),
         .en     (adv),
         .rem_i  (sqd_rem[k]),
         .root_i (sqd_root[k]),
         .rem_o  (sqd_rem[k+1]),
         .root_o (sqd_root[k+1])
      );
      fsc_sqrt_cell #(.ROOT_W(RTW), .BIT(N2 - 1 - k)) u_cell_s (
         .clock  (clock),
         .en     (adv),
         .rem_i  (sqs_rem[k]),
         .root_i (sqs_root[k]),
         .rem_o  (sqs_rem[k+1]),
         .root_o (sqs_root[k+1])
      );
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         sq_side_ff[0] <= d_side_ff;
         for (int k = 1; k < N2; k++) begin
            sq_side_ff[k] <= sq_side_ff[k-1];
         end
      end
   end

   // ------------------------------------------------------------------------
   // Stage E: remapped radius nd = (d + 1 - s) / 2
   // ------------------------------------------------------------------------
   logic [QW-1:0]  e_sum;
   logic [AW-1:0]  e_nd_ff;
   logic [RTW-1:0] e_d_ff;
   rad_side_type   e_side_ff;

   assign e_sum = QW'(sqd_root[N2]) + ONE - QW'(sqs_root[N2]);

   always_ff @(posedge clock) begin
      if (adv) begin
         e_nd_ff   <= e_sum[AW:1];
         e_d_ff    <= sqd_root[N2];
         e_side_ff <= sq_side_ff[N2-1];
      end
   end

   // ------------------------------------------------------------------------
   // Stage F: nd times each magnitude, ahead of the division by d
   // ------------------------------------------------------------------------
   logic [PW-1:0]  f_px_ff, f_py_ff;
   logic [RTW-1:0] f_d_ff;
   dir_side_type   f_side_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         f_px_ff           <= PW'(e_nd_ff) * PW'(e_side_ff.ax);
         f_py_ff           <= PW'(e_nd_ff) * PW'(e_side_ff.ay);
         f_d_ff            <= e_d_ff;
         f_side_ff.neg_x   <= e_side_ff.neg_x;
         f_side_ff.neg_y   <= e_side_ff.neg_y;
         f_side_ff.outside <= e_side_ff.outside;
      end
   end

   // ------------------------------------------------------------------------
   // Direction divider: nd * |n| / d. Since |n| <= d, the quotient stays at
   // or below 1.0 and fits AW bits.
   // ------------------------------------------------------------------------
   logic [PW-1:0]  n3x_rem [N3+1];
   logic [RTW-1:0] n3x_den [N3+1];
   logic [AW-1:0]  n3x_quo [N3+1];
   logic [PW-1:0]  n3y_rem [N3+1];
   logic [RTW-1:0] n3y_den [N3+1];
   logic [AW-1:0]  n3y_quo [N3+1];
   dir_side_type   n3_side_ff [N3];

   assign n3x_rem[0] = f_px_ff;
   assign n3x_den[0] = f_d_ff;
   assign n3x_quo[0] = '0;
   assign n3y_rem[0] = f_py_ff;
   assign n3y_den[0] = f_d_ff;
   assign n3y_quo[0] = '0;

   for (genvar k = 0; k < N3; k++) begin : g_dir
      fsc_div_cell #(.DEN_W(RTW), .QUO_W(AW), .BIT(N3 - 1 - k)) u_cell_x (
         .clock (clock),
         .en    (adv),
         .rem_i (n3x_rem[k]),
         .den_i (n3x_den[k]),
         .quo_i (n3x_quo[k]),
         .rem_o (n3x_rem[k+1]),
         .den_o (n3x_den[k+1]),
         .quo_o (n3x_quo[k+1])
      );
      fsc_div_cell #(.DEN_W(RTW), .QUO_W(AW), .BIT(N3 - 1 - k)) u_cell_y (
         .clock (clock),
         .en    (adv),
         .rem_i (n3y_rem[k]),
         .den_i (n3y_den[k]),
         .quo_i (n3y_quo[k]),
         .rem_o (n3y_rem[k+1]),
         .den_o (n3y_den[k+1]),
         .quo_o (n3y_quo[k+1])
      );
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         n3_side_ff[0] <= f_side_ff;
         for (int k = 1; k < N3; k++) begin
            n3_side_ff[k] <= n3_side_ff[k-1];
         end
      end
   end

   // ------------------------------------------------------------------------
   // Stage G: shift back to [0, 2.0]. At the center the radius is zero and
   // the point maps to the middle of the image.
   // ------------------------------------------------------------------------
   logic [QW-1:0] vx, vy;
   logic [QW-1:0] g_tx_ff, g_ty_ff;
   logic          g_out_ff;

   always_comb begin
      if (n3x_den[N3] == '0) begin
         vx = '0;
         vy = '0;
      end else begin
         vx = QW'(n3x_quo[N3]);
         vy = QW'(n3y_quo[N3]);
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         g_tx_ff  <= n3_side_ff[N3-1].neg_x ? (ONE - vx) : (ONE + vx);
         g_ty_ff  <= n3_side_ff[N3-1].neg_y ? (ONE - vy) : (ONE + vy);
         g_out_ff <= n3_side_ff[N3-1].outside;
      end
   end

   // ------------------------------------------------------------------------
   // Stage H: scale to source pixels, floor(t * size / 2.0)
   // ------------------------------------------------------------------------
   logic [PXW-1:0] h_prod_x, h_prod_y;
   logic [RW-1:0]  h_sx_ff, h_sy_ff;
   logic           h_out_ff;

   assign h_prod_x = PXW'(g_tx_ff) * PXW'(width_ff);
   assign h_prod_y = PXW'(g_ty_ff) * PXW'(height_ff);

   always_ff @(posedge clock) begin
      if (adv) begin
         h_sx_ff  <= h_prod_x[F+1 +: RW];
         h_sy_ff  <= h_prod_y[F+1 +: RW];
         h_out_ff <= g_out_ff;
      end
   end

   // ------------------------------------------------------------------------
   // Stage I: region of interest test and the output register
   // ------------------------------------------------------------------------
   logic          i_roi;
   logic [RW-1:0] i_sx_ff, i_sy_ff;
   action_type    i_act_in, i_act_ff;

   always_comb begin
      i_roi = (h_sx_ff >= roi_xb_ff) && (h_sx_ff < roi_xe_ff) &&
              (h_sy_ff >= roi_yb_ff) && (h_sy_ff < roi_ye_ff);
      if (h_out_ff) begin
         i_act_in = ACT_ZERO;
      end else if (i_roi) begin
         i_act_in = ACT_COPY;
      end else begin
         i_act_in = ACT_KEEP;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         i_sx_ff  <= h_out_ff ? '0 : h_sx_ff;
         i_sy_ff  <= h_out_ff ? '0 : h_sy_ff;
         i_act_ff <= i_act_in;
      end
   end

   assign rsp_src_x  = i_sx_ff;
   assign rsp_src_y  = i_sy_ff;
   assign rsp_action = i_act_ff;

`ifndef SYNTH
   // A cleared pixel carries no source position.
   a_zero_no_src: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_action == ACT_ZERO) |-> (rsp_src_x == '0 && rsp_src_y == '0))
      else $error("cleared pixel with nonzero source");

   // A copy always points inside the region of interest.
   a_copy_in_roi: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_action == ACT_COPY) |->
         (rsp_src_x >= roi_xb_ff && rsp_src_x < roi_xe_ff &&
          rsp_src_y >= roi_yb_ff && rsp_src_y < roi_ye_ff))
      else $error("copy source outside region of interest");

   // Reset empties the pipeline.
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");
`endif

endmodule
